@@ design/alab_pkg.sv @@
package alab_pkg;

  typedef enum logic [1:0] {
    CMD_LINE  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam int unsigned CoordW = 12;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned IntenW = 9;
  localparam int unsigned PixW   = 24;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [CoordW-1:0] x_start;
    logic signed [CoordW-1:0] y_start;
    logic signed [CoordW-1:0] x_end;
    logic signed [CoordW-1:0] y_end;
    logic [ChanW-1:0]         red_in;
    logic [ChanW-1:0]         green_in;
    logic [ChanW-1:0]         blue_in;
    logic [IntenW-1:0]        intensity;
  } cmd_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             off_screen;
  } res_t;

  // one channel of the additive blend, saturating
  function automatic logic [ChanW-1:0] add_chan(input logic [ChanW-1:0] old,
                                                input logic [ChanW-1:0] c,
                                                input logic [IntenW-1:0] inten);
    logic [IntenW+ChanW-1:0] prod;
    logic [IntenW+ChanW-1:0] s;
    prod = inten * c;
    s = {{IntenW{1'b0}}, old} + {8'd0, prod[IntenW+ChanW-1:8]};
    add_chan = (s > 17'd255) ? 8'hFF : s[ChanW-1:0];
  endfunction

endpackage

@@ design/alab_if.sv @@
interface alab_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/alab_ram.sv @@
module alab_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/alab_div.sv @@
// Restoring divider: quotient of |num| / den, Nb steps, truncated toward zero.
module alab_div #(
  parameter int unsigned Nb = 29,
  parameter int unsigned Db = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [Nb-1:0] num_i,
  input  logic [Db-1:0] den_i,
  output logic          done_o,
  output logic [Nb-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(Nb + 1);
  logic [Nb-1:0]   quo_q, quo_d;
  logic [Db:0]     rem_q, rem_d;
  logic [Db-1:0]   den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [Db:0]     trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[Db-1:0], quo_q[Nb-1]};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; cnt_d = CntW'(Nb); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[Nb-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[Nb-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

@@ design/antialiased_line_additive_blend.sv @@
// channel | dir | payload              | accepted when
// cmd     | in  | alab_pkg::cmd_t      | cmd.valid & cmd.ready
// res     | out | alab_pkg::res_t      | res.valid & res.ready
// After reset a clearing pass writes black to all COLS*ROWS pixels, one per
// cycle, with cmd.ready low. A pixel blend or read goes through dispatch,
// read, write back and done (dispatch and done only when off screen). In a
// line an on-screen pixel takes dispatch, read and write back, an off-screen
// one only dispatch; a sloped line also waits on the gradient divider.
// A finished result waits in its output register; the next command is taken
// only once that register has been drained.
module antialiased_line_additive_blend #(
  parameter int unsigned SCREEN_COLUMNS = 128,
  parameter int unsigned SCREEN_ROWS    = 128,
  parameter int unsigned FRACTION_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  alab_if.sink   cmd,
  alab_if.source res
);
  localparam int unsigned Depth = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = 14;              // coordinate math width
  localparam int unsigned PW    = FRACTION_BITS + CW + 1;
  localparam int unsigned NB    = FRACTION_BITS + 13;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HV, ST_END1, ST_END2, ST_DIV, ST_STEP,
    ST_PAIR, ST_RD, ST_WR, ST_DONE
  } state_e;

  state_e state_q;
  alab_pkg::cmd_t c_q;
  logic [AW-1:0] clr_q;
  logic signed [CW-1:0] px_q, py_q;      // pixel to blend
  logic [8:0] pint_q;                     // its intensity
  state_e ret_q;                          // state after the blend
  logic signed [CW-1:0] run_q, runend_q; // h/v run or major axis
  logic signed [CW-1:0] mx1_q, my1_q, mx2_q;
  logic steep_q, neg_q;
  logic signed [PW-1:0] grad_q, pos_q;
  logic [8:0] ihi_q;
  logic signed [CW-1:0] base_q;
  logic rvalid_q;
  alab_pkg::res_t rdata_q;

  // memory
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [23:0] wdata, rdata;
  alab_ram #(.Width(24), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata));

  function automatic logic on_scr(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    return x >= 0 && x < $signed(CW'(SCREEN_COLUMNS)) &&
           y >= 0 && y < $signed(CW'(SCREEN_ROWS));
  endfunction

  function automatic logic [AW-1:0] addr_of(logic signed [CW-1:0] x,
                                            logic signed [CW-1:0] y);
    logic [CW-1:0] row;
    logic [2*CW-1:0] a;
    row = CW'(SCREEN_ROWS - 1) - CW'(y);
    a = row * CW'(SCREEN_COLUMNS) + {{CW{1'b0}}, CW'(x)};
    return a[AW-1:0];
  endfunction

  // sign-extended inputs
  logic signed [CW-1:0] xs, ys, xe, ye;
  assign xs = CW'(c_q.x_start);
  assign ys = CW'(c_q.y_start);
  assign xe = CW'(c_q.x_end);
  assign ye = CW'(c_q.y_end);

  logic signed [CW-1:0] dxr, dyr, axr, ayr;
  assign dxr = xe - xs;
  assign dyr = ye - ys;
  assign axr = dxr < 0 ? -dxr : dxr;
  assign ayr = dyr < 0 ? -dyr : dyr;

  // divider for |dy|<<F / dx
  logic div_start, div_done;
  logic [NB-1:0] div_q;
  logic signed [CW-1:0] ndy;
  logic [CW-1:0] ady;
  logic signed [CW-1:0] sx1, sy1, sx2, sy2, tdx;
  always_comb begin
    sx1 = steep_q ? ys : xs; sy1 = steep_q ? xs : ys;
    sx2 = steep_q ? ye : xe; sy2 = steep_q ? xe : ye;
    if (sx2 < sx1) begin
      tdx = sx1 - sx2; ndy = sy1 - sy2;
    end else begin
      tdx = sx2 - sx1; ndy = sy2 - sy1;
    end
    ady = ndy < 0 ? CW'(-ndy) : CW'(ndy);
  end
  alab_div #(.Nb(NB), .Db(13)) u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i(NB'({ady, {FRACTION_BITS{1'b0}}})), .den_i(tdx[12:0]),
    .done_o(div_done), .quo_o(div_q));

  // per-step weights from position
  logic signed [CW-1:0] base_c;
  logic [7:0] w_c;
  logic [17:0] ilo_p, ihi_p;
  assign base_c = CW'(pos_q >>> FRACTION_BITS);
  assign w_c    = pos_q[FRACTION_BITS-1 -: 8];
  assign ilo_p  = c_q.intensity * (10'd256 - {2'd0, w_c});
  assign ihi_p  = c_q.intensity * {1'b0, w_c};

  logic [23:0] blended;
  assign blended = {alab_pkg::add_chan(rdata[23:16], c_q.red_in, pint_q),
                    alab_pkg::add_chan(rdata[15:8], c_q.green_in, pint_q),
                    alab_pkg::add_chan(rdata[7:0], c_q.blue_in, pint_q)};

  assign raddr = addr_of(px_q, py_q);
  always_comb begin
    we = 1'b0; waddr = addr_of(px_q, py_q); wdata = blended;
    if (state_q == ST_CLEAR) begin
      we = 1'b1; waddr = clr_q; wdata = '0;
    end else if (state_q == ST_WR && c_q.cmd == alab_pkg::CMD_LINE ||
                 state_q == ST_WR && c_q.cmd == alab_pkg::CMD_PIXEL) begin
      we = 1'b1;
    end
  end
  assign div_start = state_q == ST_END2 && ret_q == ST_DIV;

  assign cmd.ready = state_q == ST_IDLE && !rvalid_q;
  assign res.valid = rvalid_q;
  assign res.data  = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; rvalid_q <= 1'b0; ret_q <= ST_IDLE;
    end else begin
      if (res.valid && res.ready) rvalid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(Depth - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (cmd.valid && cmd.ready) begin
            c_q <= cmd.data;
            px_q <= CW'(cmd.data.x_start);
            py_q <= CW'(cmd.data.y_start);
            pint_q <= cmd.data.intensity;
            state_q <= ST_HV;
          end
        end
        ST_HV: begin
          // dispatch; off_screen only for pixel and read commands
          rdata_q <= {24'd0, (c_q.cmd == alab_pkg::CMD_PIXEL ||
                              c_q.cmd == alab_pkg::CMD_READ) && !on_scr(xs, ys)};
          if (c_q.cmd == alab_pkg::CMD_PIXEL || c_q.cmd == alab_pkg::CMD_READ) begin
            ret_q <= ST_DONE;
            state_q <= on_scr(xs, ys) ? ST_RD : ST_DONE;
          end else if (c_q.cmd == alab_pkg::CMD_LINE) begin
            if (xs == xe) begin
              run_q <= ys < ye ? ys : ye; runend_q <= ys < ye ? ye : ys;
              steep_q <= 1'b1; state_q <= ST_STEP; neg_q <= 1'b1;
            end else if (ys == ye) begin
              run_q <= xs < xe ? xs : xe; runend_q <= xs < xe ? xe : xs;
              steep_q <= 1'b0; state_q <= ST_STEP; neg_q <= 1'b1;
            end else begin
              steep_q <= ayr > axr; neg_q <= 1'b0;
              ret_q <= ST_END1;
              state_q <= on_scr(xs, ys) ? ST_RD : ST_END1;
            end
          end else state_q <= ST_DONE;
        end
        ST_RD: state_q <= ST_WR;   // read data valid next
        ST_WR: begin
          if (c_q.cmd == alab_pkg::CMD_READ) begin
            rdata_q.red_out <= rdata[23:16];
            rdata_q.green_out <= rdata[15:8];
            rdata_q.blue_out <= rdata[7:0];
          end
          state_q <= ret_q;
        end
        ST_END1: begin
          px_q <= xe; py_q <= ye; ret_q <= ST_END2;
          state_q <= on_scr(xe, ye) ? ST_RD : ST_END2;
        end
        ST_END2: begin
          if (ret_q == ST_END2) begin
            ret_q <= ST_DIV;   // next cycle starts the divider
          end else begin
            if (sx2 < sx1) begin
              mx1_q <= sx2; my1_q <= sy2; mx2_q <= sx1;
            end else begin
              mx1_q <= sx1; my1_q <= sy1; mx2_q <= sx2;
            end
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            grad_q <= ndy < 0 ? -PW'(div_q) : PW'(div_q);
            pos_q <= (PW'(my1_q) <<< FRACTION_BITS) +
                     (ndy < 0 ? -PW'(div_q) : PW'(div_q));
            run_q <= mx1_q + 1'b1; runend_q <= mx2_q;
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (neg_q) begin
            // horizontal or vertical run, inclusive
            if (run_q > runend_q) state_q <= ST_DONE;
            else begin
              px_q <= steep_q ? xs : run_q; py_q <= steep_q ? run_q : ys;
              pint_q <= c_q.intensity; run_q <= run_q + 1'b1;
              ret_q <= ST_STEP;
              state_q <= on_scr(steep_q ? xs : run_q, steep_q ? run_q : ys)
                         ? ST_RD : ST_STEP;
            end
          end else if (run_q >= runend_q) state_q <= ST_DONE;
          else begin
            base_q <= base_c; ihi_q <= ihi_p[16:8];
            px_q <= steep_q ? base_c : run_q; py_q <= steep_q ? run_q : base_c;
            pint_q <= ilo_p[16:8];
            ret_q <= ST_PAIR;
            state_q <= on_scr(steep_q ? base_c : run_q, steep_q ? run_q : base_c)
                       ? ST_RD : ST_PAIR;
          end
        end
        ST_PAIR: begin
          px_q <= steep_q ? base_q + 1'b1 : run_q;
          py_q <= steep_q ? run_q : base_q + 1'b1;
          pint_q <= ihi_q; ret_q <= ST_STEP;
          run_q <= run_q + 1'b1; pos_q <= pos_q + grad_q;
          state_q <= on_scr(steep_q ? base_q + 1'b1 : run_q,
                            steep_q ? run_q : base_q + 1'b1) ? ST_RD : ST_STEP;
        end
        ST_DONE: begin
          rvalid_q <= 1'b1; state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
